// ===== src/bma_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and codes for the boxcar moving average block.
package bma_pkg;

   localparam int DATA_W = 16;
   localparam int WINDOW_LENGTH_DEF = 8;

   // Result queue depth covers every beat that can be in flight at once.
   localparam int OUTQ_DEPTH = 6;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   localparam logic ACTION_PRELOAD = 1'b0;
   localparam logic ACTION_SAMPLE  = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              action;
      logic [DATA_W-1:0] value;
      logic              use_mem;
      logic [DATA_W-1:0] alt;
      logic              full;
   } bma_issue_type;

   typedef struct packed {
      logic [DATA_W-1:0] average;
      logic              window_full;
   } bma_result_type;

endpackage

// ===== src/boxcar_moving_average_top.sv =====
`timescale 1ns / 1ps
// Boxcar moving average top level: ring control, running sum, divider, result queue.
// A request beat passes through the accumulator input and sum registers and the
// divider magnitude and product registers into the result queue. Throughput: one
// beat per cycle while credits remain; req_stall holds requests once they run out.
// Reset (synchronous, active high) empties the pipeline and the result queue,
// zeroes the window and clears signed mode; no clearing pass is needed.
module boxcar_moving_average_top
   import bma_pkg::*;
#(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_average,
   output logic              rsp_window_full,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_signed_mode
);

   localparam int AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int K  = DATA_W + $clog2(WINDOW_LENGTH);

   // Control state that advances as each beat is taken. The ring itself is
   // never swept on a preload: an entry is read from memory only once the
   // ring has wrapped, which guarantees it was written since the preload.
   // Before that, the overwritten entry still holds the preload value.
   logic              mode_ff;
   logic [AW-1:0]     pos_ff, pos_in;
   logic              full_ff, full_in;
   logic [DATA_W-1:0] fill_ff;
   logic              last_sample_ff;
   logic [AW-1:0]     last_addr_ff;
   logic [DATA_W-1:0] last_value_ff;
   logic [OUTQ_CNT_W-1:0] credit_ff, credit_in;

   logic              req_accept;
   logic              rsp_accept;
   logic              wrap;
   logic              fwd;
   bma_issue_type     issue;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_data;

   logic              acc_valid;
   logic              acc_full;
   logic signed [K:0] acc_sum;

   logic              div_valid;
   bma_result_type    div_result;
   bma_result_type    head_data;

   // The configuration register can always be written; the user must change it only
   // while no beat is in flight, as the block itself does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_signed_mode;
      end
   end

   // Credit counter: beats taken but not yet delivered. The result queue is
   // deep enough for every credit, so the pipeline itself never stalls and
   // the request side keeps a full rate while the response side drains.
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (credit_ff >= OUTQ_CNT_W'(OUTQ_DEPTH));

   always_comb begin
      case ({req_accept, rsp_accept})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   // Write position and window-full flag. The flag sets on the first wrap
   // and stays set until the next preload.
   assign wrap = (pos_ff == AW'(WINDOW_LENGTH - 1));

   always_comb begin
      pos_in  = pos_ff;
      full_in = full_ff;
      if (req_accept) begin
         if (req_action == ACTION_PRELOAD) begin
            pos_in  = '0;
            full_in = 1'b0;
         end else begin
            pos_in  = wrap ? '0 : pos_ff + 1'b1;
            full_in = full_ff || wrap;
         end
      end
   end

   // The memory read issued now sees the old contents of an entry that the
   // previous beat writes back in this same cycle. That only happens with a
   // one-entry window; the previous sample value is forwarded instead.
   assign fwd = last_sample_ff && (last_addr_ff == pos_ff);

   always_comb begin
      issue.valid   = req_accept;
      issue.action  = req_action;
      issue.value   = req_value;
      issue.use_mem = full_ff && !fwd;
      issue.alt     = fwd ? last_value_ff : fill_ff;
      issue.full    = full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         full_ff        <= 1'b0;
         fill_ff        <= '0;
         last_sample_ff <= 1'b0;
         credit_ff      <= '0;
      end else begin
         pos_ff         <= pos_in;
         full_ff        <= full_in;
         last_sample_ff <= req_accept && (req_action == ACTION_SAMPLE);
         credit_ff      <= credit_in;
         if (req_accept && (req_action == ACTION_PRELOAD)) begin
            fill_ff <= req_value;
         end
      end
      if (req_accept) begin
         last_addr_ff  <= pos_ff;
         last_value_ff <= req_value;
      end
   end

   bma_ring #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .AW            (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   // Running sums for both interpretations are kept, so a mode change
   // between windows needs no recomputation.
   bma_accum #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .AW            (AW),
      .K             (K)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .signed_mode (mode_ff),
      .issue       (issue),
      .issue_addr  (pos_ff),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .out_valid   (acc_valid),
      .out_full    (acc_full),
      .out_sum     (acc_sum)
   );

   bma_divide #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .K             (K)
   ) u_divide (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (acc_valid),
      .in_full    (acc_full),
      .in_sum     (acc_sum),
      .out_valid  (div_valid),
      .out_result (div_result)
   );

   bma_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (div_valid),
      .push_data  (div_result),
      .pop        (rsp_accept),
      .head_valid (rsp_valid),
      .head_data  (head_data)
   );

   assign rsp_average     = head_data.average;
   assign rsp_window_full = head_data.window_full;

endmodule

// ===== src/bma_ring.sv =====
`timescale 1ns / 1ps
// Sample ring memory with one write port and one registered read port.
module bma_ring
   import bma_pkg::*;
#(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int AW = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [WINDOW_LENGTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bma_accum.sv =====
`timescale 1ns / 1ps
// Running-sum stage: retires one beat per cycle and writes the sample back.
module bma_accum
   import bma_pkg::*;
#(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int AW = 1,
   parameter int K = DATA_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                signed_mode,
   input  bma_issue_type       issue,
   input  logic [AW-1:0]       issue_addr,
   input  logic [DATA_W-1:0]   rd_data,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output logic [DATA_W-1:0]   wr_data,
   output logic                out_valid,
   output logic                out_full,
   output logic signed [K:0]   out_sum
);

   bma_issue_type      s1_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic [K-1:0]       usum_ff, usum_in;
   logic signed [K:0]  ssum_ff, ssum_in;
   logic [DATA_W-1:0]  old_value;
   logic signed [K:0]  old_ext, new_ext;
   logic               out_valid_ff, out_full_ff;
   logic signed [K:0]  out_sum_ff, out_sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= issue.valid;
      end
      s1_ff.action  <= issue.action;
      s1_ff.value   <= issue.value;
      s1_ff.use_mem <= issue.use_mem;
      s1_ff.alt     <= issue.alt;
      s1_ff.full    <= issue.full;
      s1_addr_ff    <= issue_addr;
   end

   // The overwritten entry comes from memory once the ring is full, else
   // from the preload value or the beat that just wrote the same entry.
   assign old_value = s1_ff.use_mem ? rd_data : s1_ff.alt;
   assign old_ext   = (K+1)'($signed(old_value));
   assign new_ext   = (K+1)'($signed(s1_ff.value));

   always_comb begin
      usum_in = usum_ff;
      ssum_in = ssum_ff;
      if (s1_ff.valid) begin
         if (s1_ff.action == ACTION_PRELOAD) begin
            usum_in = K'(s1_ff.value) * K'(WINDOW_LENGTH);
            ssum_in = new_ext * $signed((K+1)'(WINDOW_LENGTH));
         end else begin
            usum_in = usum_ff - K'(old_value) + K'(s1_ff.value);
            ssum_in = ssum_ff - old_ext + new_ext;
         end
      end
      out_sum_in = signed_mode ? ssum_in : $signed({1'b0, usum_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usum_ff      <= '0;
         ssum_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         usum_ff      <= usum_in;
         ssum_ff      <= ssum_in;
         out_valid_ff <= s1_ff.valid;
      end
      out_full_ff <= s1_ff.full;
      out_sum_ff  <= out_sum_in;
   end

   assign wr_en     = s1_ff.valid && (s1_ff.action == ACTION_SAMPLE);
   assign wr_addr   = s1_addr_ff;
   assign wr_data   = s1_ff.value;
   assign out_valid = out_valid_ff;
   assign out_full  = out_full_ff;
   assign out_sum   = out_sum_ff;

endmodule

// ===== src/bma_divide.sv =====
`timescale 1ns / 1ps
// Division of the window sum by the window length via reciprocal multiply.
module bma_divide
   import bma_pkg::*;
#(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int K = DATA_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_full,
   input  logic signed [K:0] in_sum,
   output logic              out_valid,
   output bma_result_type    out_result
);

   localparam int L  = $clog2(WINDOW_LENGTH);
   localparam int S  = K + L;
   localparam int MW = K + 2;
   localparam int PW = K + MW;
   localparam logic [63:0] SCALE      = 64'd1 << S;
   localparam logic [63:0] RECIP_FULL =
      (SCALE + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
   localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

   logic              mag_valid_ff, mag_neg_ff, mag_full_ff;
   logic [K-1:0]      mag_ff, mag_in;
   logic              prod_valid_ff, prod_neg_ff, prod_full_ff;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [DATA_W-1:0] quotient;

   // Truncation toward zero: divide the magnitude, then restore the sign.
   assign mag_in  = in_sum[K] ? K'(-in_sum) : in_sum[K-1:0];
   assign prod_in = PW'(mag_ff) * PW'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         mag_valid_ff  <= in_valid;
         prod_valid_ff <= mag_valid_ff;
      end
      mag_ff       <= mag_in;
      mag_neg_ff   <= in_sum[K];
      mag_full_ff  <= in_full;
      prod_ff      <= prod_in;
      prod_neg_ff  <= mag_neg_ff;
      prod_full_ff <= mag_full_ff;
   end

   assign quotient               = prod_ff[S +: DATA_W];
   assign out_valid              = prod_valid_ff;
   assign out_result.average     = prod_neg_ff ? (DATA_W'(0) - quotient) : quotient;
   assign out_result.window_full = prod_full_ff;

endmodule

// ===== src/bma_outq.sv =====
`timescale 1ns / 1ps
// Result queue that decouples the pipeline from the response stall.
module bma_outq
   import bma_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  bma_result_type push_data,
   input  logic           pop,
   output logic           head_valid,
   output bma_result_type head_data
);

   bma_result_type          entry_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

endmodule

// ===== src/bma_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the boxcar moving average top level, with its bind.
module bma_checker
   import bma_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [DATA_W-1:0] rsp_average,
   input logic              rsp_window_full
);

   logic [OUTQ_CNT_W:0] pending_ff;
   logic                req_take;
   logic                rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         case ({req_take, rsp_take})
            2'b10:   pending_ff <= pending_ff + 1'b1;
            2'b01:   pending_ff <= pending_ff - 1'b1;
            default: pending_ff <= pending_ff;
         endcase
      end
   end

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average)
                                 && $stable(rsp_window_full))
      else $error("stalled response beat changed");

   a_rsp_owed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response beat without a pending request beat");

   a_idle_open : assert property (@(posedge clock) disable iff (reset)
      pending_ff == '0 |-> !req_stall)
      else $error("request side stalled with nothing in flight");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind boxcar_moving_average_top bma_checker u_bma_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_average     (rsp_average),
   .rsp_window_full (rsp_window_full)
);
